[rtl/assert_macros.svh]
// assertion helpers shared by the tachometer modules
// each macro expects clk and rst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define FT_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define FT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

[rtl/fantach_pkg.sv]
package fantach_pkg;

    // sizes
    localparam int CHANNELS    = 4;
    localparam int CH_BITS     = 2;
    localparam int RING_DEPTH  = 16;
    localparam int RING_BITS   = $clog2(RING_DEPTH);
    localparam int COUNT_BITS  = $clog2(RING_DEPTH + 1);
    localparam int SHIFT_BITS  = $clog2(RING_DEPTH);
    localparam int TIME_BITS   = 48;
    localparam int PERIOD_BITS = 18;
    localparam int ROW_BITS    = PERIOD_BITS + 1;
    localparam int M2_BITS     = PERIOD_BITS + 1;
    localparam int PPR_BITS    = 4;
    localparam int DEN_BITS    = M2_BITS + PPR_BITS;
    localparam int NUM_BITS    = 31;
    localparam int DIV_CNT_BITS = $clog2(NUM_BITS + 1);
    localparam int RPM_BITS    = 17;
    localparam int MEM_DEPTH   = CHANNELS * RING_DEPTH;
    localparam int ADDR_BITS   = CH_BITS + RING_BITS;
    localparam int QDEPTH      = 2;
    localparam int QPTR_BITS   = 1;
    localparam int QCNT_BITS   = 2;
    localparam int EMA_BITS    = 20;
    localparam int DIV5_SHIFT  = 24;
    localparam int DIV5_BITS   = 22;
    localparam int PROD_BITS   = EMA_BITS + DIV5_BITS;

    // arithmetic constants
    localparam logic [NUM_BITS-1:0]    RPM_NUM   = 31'd1920000000;
    localparam logic [RPM_BITS-1:0]    RPM_MAX   = 17'h1FFFF;
    localparam logic [DIV5_BITS-1:0]   DIV5_MUL  = 22'd3355444;
    localparam logic [1:0]             SKIP_AFTER_SELECT = 2'd2;
    localparam logic [ROW_BITS-1:0]    ROW_EMPTY = ROW_BITS'(1) << PERIOD_BITS;
    localparam logic [PERIOD_BITS-1:0] PERIOD_MAX = '1;
    localparam logic [TIME_BITS-1:0]   TIME_MAX  = '1;

    // request codes on the input channel
    localparam logic [1:0] REQ_EDGE    = 2'd0;
    localparam logic [1:0] REQ_MEASURE = 2'd1;
    localparam logic [1:0] REQ_SELECT  = 2'd2;

    // register indexes
    localparam logic [2:0] CFG_MIN_LOW    = 3'd0;
    localparam logic [2:0] CFG_MIN_PERIOD = 3'd1;
    localparam logic [2:0] CFG_MAX_PERIOD = 3'd2;
    localparam logic [2:0] CFG_STOP_TO    = 3'd3;
    localparam logic [2:0] CFG_BLANK      = 3'd4;
    localparam logic [2:0] CFG_MIN_SAMP   = 3'd5;
    localparam logic [2:0] CFG_PPR        = 3'd6;
    localparam logic [2:0] CFG_EPS        = 3'd7;

    typedef enum logic [1:0] {
        OP_EDGE,
        OP_MEASURE,
        OP_SELECT
    } op_t;

    typedef struct packed {
        op_t                  op;
        logic [CH_BITS-1:0]   ch;
        logic [TIME_BITS-1:0] now;
        logic                 level;
    } item_t;

    typedef struct packed {
        logic [15:0]          min_low_width_us;
        logic [17:0]          min_period_us;
        logic [17:0]          max_period_us;
        logic [23:0]          stop_timeout_us;
        logic [15:0]          switch_blank_us;
        logic [4:0]           min_samples;
        logic [PPR_BITS-1:0]  pulses_per_rev;
        logic [15:0]          change_eps_q4;
    } cfg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EXEC,
        ST_EDGE,
        ST_STOPCHK,
        ST_LOAD,
        ST_SHIFT,
        ST_MUL,
        ST_DIVGO,
        ST_DIV,
        ST_EMA,
        ST_EMA_DIV,
        ST_REPORT,
        ST_INVALID,
        ST_OUT
    } back_state_t;

endpackage

[rtl/fantach_div.sv]
module fantach_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [fantach_pkg::DEN_BITS-1:0] den,
    output logic                          done,
    output logic [fantach_pkg::NUM_BITS-1:0] quot
);
    import fantach_pkg::*;

    logic [NUM_BITS-1:0]     dvd_reg;
    logic [NUM_BITS-1:0]     quot_reg;
    logic [DEN_BITS-1:0]     rem_reg;
    logic [DEN_BITS-1:0]     den_reg;
    logic [DIV_CNT_BITS-1:0] cnt_reg;
    logic                    busy_reg;
    logic                    done_reg;
    logic [DEN_BITS:0]       trial;
    logic                    fits;

    // one quotient bit per cycle, restoring
    assign trial = {rem_reg, dvd_reg[NUM_BITS-1]};
    assign fits  = trial >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_CNT_BITS'(NUM_BITS);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == DIV_CNT_BITS'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath, rounding term added to the dividend at start
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg  <= RPM_NUM + NUM_BITS'(den >> 1);
            den_reg  <= den;
            rem_reg  <= '0;
            quot_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg  <= {dvd_reg[NUM_BITS-2:0], 1'b0};
            quot_reg <= {quot_reg[NUM_BITS-2:0], fits};
            rem_reg  <= fits ? DEN_BITS'(trial - {1'b0, den_reg}) : trial[DEN_BITS-1:0];
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

[rtl/fantach_front.sv]
`include "assert_macros.svh"

module fantach_front (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             req_valid,
    output logic                             req_stall,
    input  logic [1:0]                       req_type,
    input  logic [fantach_pkg::CH_BITS-1:0]  channel,
    input  logic [fantach_pkg::TIME_BITS-1:0] now_us,
    input  logic                             level,
    output logic                             q_valid,
    output fantach_pkg::item_t               q_item,
    input  logic                             q_pop
);
    import fantach_pkg::*;

    item_t                 fifo_reg [QDEPTH];
    logic [QPTR_BITS-1:0]  wr_ptr_reg;
    logic [QPTR_BITS-1:0]  rd_ptr_reg;
    logic [QCNT_BITS-1:0]  count_reg;
    logic                  accept;
    logic                  keep;
    logic                  push;
    item_t                 item_in;

    // classify the request, reserved type is dropped here
    always_comb
    begin
        keep = 1'b1;
        item_in.op = OP_EDGE;
        case (req_type)
            REQ_EDGE:    item_in.op = OP_EDGE;
            REQ_MEASURE: item_in.op = OP_MEASURE;
            REQ_SELECT:  item_in.op = OP_SELECT;
            default:     keep = 1'b0;
        endcase
        item_in.ch    = channel;
        item_in.now   = now_us;
        item_in.level = level;
    end

    assign req_stall = count_reg == QCNT_BITS'(QDEPTH);
    assign accept    = req_valid && !req_stall;
    assign push      = accept && keep;
    assign q_valid   = count_reg != '0;
    assign q_item    = fifo_reg[rd_ptr_reg];

    // queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (q_pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !q_pop)
                count_reg <= count_reg + 1'b1;
            else if (q_pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
            fifo_reg[wr_ptr_reg] <= item_in;
    end

    `FT_ASSERT_IMP(a_count_bound, 1'b1, count_reg <= QCNT_BITS'(QDEPTH))
    `FT_ASSERT_NEXT(a_push_grows, push && !q_pop, count_reg == $past(count_reg) + 2'd1)
    `FT_ASSERT_NEXT(a_pop_shrinks, q_pop && !push, count_reg == $past(count_reg) - 2'd1)

endmodule

[rtl/fantach_back.sv]
`include "assert_macros.svh"

module fantach_back (
    input  logic                              clk,
    input  logic                              rst_n,
    input  fantach_pkg::cfg_t                 cfg,
    input  logic                              q_valid,
    input  fantach_pkg::item_t                q_item,
    output logic                              q_pop,
    output logic                              res_valid,
    input  logic                              res_stall,
    output logic [fantach_pkg::CH_BITS-1:0]   out_channel,
    output logic [fantach_pkg::RPM_BITS-1:0]  rpm_q4,
    output logic                              rpm_valid,
    output logic                              changed,
    output logic                              stopped
);
    import fantach_pkg::*;

    back_state_t state_reg, state_next;

    // current item
    op_t                  op_reg;
    logic [CH_BITS-1:0]   ch_reg;
    logic [TIME_BITS-1:0] now_reg;
    logic                 level_reg;

    // per-channel state
    logic [COUNT_BITS-1:0] count_reg [CHANNELS];
    logic [RING_BITS-1:0]  widx_reg  [CHANNELS];
    logic [TIME_BITS-1:0]  fall_reg  [CHANNELS];
    logic                  fall_ok_reg [CHANNELS];
    logic [TIME_BITS-1:0]  low_reg   [CHANNELS];
    logic                  low_ok_reg [CHANNELS];
    logic [TIME_BITS-1:0]  good_reg  [CHANNELS];
    logic                  good_ok_reg [CHANNELS];
    logic [1:0]            skip_reg  [CHANNELS];
    logic [RPM_BITS-1:0]   filt_reg  [CHANNELS];
    logic                  filt_ok_reg [CHANNELS];
    logic [RPM_BITS-1:0]   rep_reg   [CHANNELS];
    logic                  rep_ok_reg [CHANNELS];
    logic [CH_BITS-1:0]    active_reg;
    logic [TIME_BITS-1:0]  blank_reg;

    // edge and stop check flags
    logic                 e_blank_reg, e_early_reg, e_back_reg;
    logic [TIME_BITS-1:0] e_width_reg, e_per_reg;
    logic                 s_ge_reg;
    logic [TIME_BITS-1:0] s_diff_reg;

    // median and rpm path
    logic [PERIOD_BITS-1:0] ring_mem [MEM_DEPTH];
    logic [PERIOD_BITS-1:0] rd_data_reg;
    logic [ROW_BITS-1:0]    row_reg [RING_DEPTH];
    logic [ROW_BITS-1:0]    row_ins [RING_DEPTH];
    logic [COUNT_BITS-1:0]  ld_addr_reg, ins_cnt_reg, n_reg;
    logic                   rd_valid_reg;
    logic [SHIFT_BITS-1:0]  sh_reg;
    logic [M2_BITS-1:0]     m2_reg, m2_calc;
    logic [DEN_BITS-1:0]    den_reg;
    logic [RPM_BITS-1:0]    raw_reg;
    logic [PROD_BITS-1:0]   prod_reg;
    logic [EMA_BITS-1:0]    ema_sum;
    logic [NUM_BITS-1:0]    quot;
    logic                   div_done;

    // staged result and output register
    logic [RPM_BITS-1:0] r_rpm_reg;
    logic                r_valid_reg, r_changed_reg, r_stopped_reg;
    logic                res_valid_reg;
    logic [CH_BITS-1:0]  out_ch_reg;
    logic [RPM_BITS-1:0] out_rpm_reg;
    logic                out_valid_reg, out_changed_reg, out_stopped_reg;

    // control
    logic                 div_start, out_load, out_free;
    logic                 stop_now, enough, edge_ok, period_ok;
    logic [RPM_BITS-1:0]  rep_diff;
    logic [PPR_BITS-1:0]  ppr_eff;
    logic [TIME_BITS:0]   blank_sum;
    logic [PERIOD_BITS-1:0] per_sat;
    logic [RING_BITS-1:0] widx_cur;
    logic [ADDR_BITS-1:0] wr_addr, rd_addr;

    fantach_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .den   (den_reg),
        .done  (div_done),
        .quot  (quot)
    );

    // shared decisions
    assign stop_now  = good_ok_reg[ch_reg] && s_ge_reg
                       && (s_diff_reg > TIME_BITS'(cfg.stop_timeout_us));
    assign enough    = good_ok_reg[ch_reg] && (count_reg[ch_reg] != '0)
                       && (count_reg[ch_reg] >= cfg.min_samples);
    assign edge_ok   = !e_early_reg && (e_width_reg >= TIME_BITS'(cfg.min_low_width_us));
    assign period_ok = !e_back_reg && (e_per_reg >= TIME_BITS'(cfg.min_period_us))
                       && (e_per_reg <= TIME_BITS'(cfg.max_period_us));
    assign per_sat   = (e_per_reg > TIME_BITS'(PERIOD_MAX)) ? PERIOD_MAX
                       : e_per_reg[PERIOD_BITS-1:0];
    assign ppr_eff   = (cfg.pulses_per_rev == '0) ? PPR_BITS'(1) : cfg.pulses_per_rev;
    assign blank_sum = {1'b0, now_reg} + (TIME_BITS + 1)'(cfg.switch_blank_us);
    assign rep_diff  = (filt_reg[ch_reg] > rep_reg[ch_reg])
                       ? filt_reg[ch_reg] - rep_reg[ch_reg]
                       : rep_reg[ch_reg] - filt_reg[ch_reg];
    assign ema_sum   = EMA_BITS'(filt_reg[ch_reg]) + {1'b0, raw_reg, 2'b00}
                       + EMA_BITS'(2);
    assign widx_cur  = widx_reg[ch_reg];
    assign wr_addr   = {ch_reg, widx_cur};
    assign rd_addr   = {ch_reg, ld_addr_reg[RING_BITS-1:0]};
    assign out_free  = !res_valid_reg || !res_stall;

    // doubled median after shifting: the leading cell twice for an odd count, else the two leading cells summed
    assign m2_calc = n_reg[0] ? {row_reg[0][PERIOD_BITS-1:0], 1'b0}
                   : M2_BITS'(row_reg[0][PERIOD_BITS-1:0])
                     + M2_BITS'(row_reg[1][PERIOD_BITS-1:0]);

    // insertion into the sorted row, empty cells hold a value above any period
    always_comb
    begin
        for (int i = 0; i < RING_DEPTH; i++)
        begin
            if (row_reg[i] > {1'b0, rd_data_reg})
            begin
                if (i == 0)
                    row_ins[i] = {1'b0, rd_data_reg};
                else if (row_reg[i-1] <= {1'b0, rd_data_reg})
                    row_ins[i] = {1'b0, rd_data_reg};
                else
                    row_ins[i] = row_reg[i-1];
            end
            else
                row_ins[i] = row_reg[i];
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (q_valid)
                    state_next = ST_EXEC;
            ST_EXEC:
                case (op_reg)
                    OP_EDGE:    state_next = ST_EDGE;
                    OP_MEASURE: state_next = ST_STOPCHK;
                    default:    state_next = ST_IDLE;
                endcase
            ST_EDGE:
                state_next = ST_IDLE;
            ST_STOPCHK:
                if (stop_now)
                    state_next = ST_OUT;
                else if (enough)
                    state_next = ST_LOAD;
                else
                    state_next = ST_INVALID;
            ST_LOAD:
                if (rd_valid_reg && (ins_cnt_reg == n_reg - 1'b1))
                    state_next = ST_SHIFT;
            ST_SHIFT:
                if (sh_reg == '0)
                    state_next = ST_MUL;
            ST_MUL:
                state_next = (m2_reg == '0) ? ST_INVALID : ST_DIVGO;
            ST_DIVGO:
                state_next = ST_DIV;
            ST_DIV:
                if (div_done)
                    state_next = ST_EMA;
            ST_EMA:
                state_next = filt_ok_reg[ch_reg] ? ST_EMA_DIV : ST_REPORT;
            ST_EMA_DIV:
                state_next = ST_REPORT;
            ST_REPORT:
                state_next = ST_OUT;
            ST_INVALID:
                state_next = ST_OUT;
            ST_OUT:
                if (out_free)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        q_pop     = (state_reg == ST_IDLE) && q_valid;
        div_start = state_reg == ST_DIVGO;
        out_load  = (state_reg == ST_OUT) && out_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // channel state and global selection
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < CHANNELS; c++)
            begin
                count_reg[c]   <= '0;
                widx_reg[c]    <= '0;
                fall_reg[c]    <= '0;
                fall_ok_reg[c] <= 1'b0;
                low_reg[c]     <= '0;
                low_ok_reg[c]  <= 1'b0;
                good_reg[c]    <= '0;
                good_ok_reg[c] <= 1'b0;
                skip_reg[c]    <= '0;
                filt_reg[c]    <= '0;
                filt_ok_reg[c] <= 1'b0;
                rep_reg[c]     <= '0;
                rep_ok_reg[c]  <= 1'b0;
            end
            active_reg <= '0;
            blank_reg  <= '0;
        end
        else
        begin
            case (state_reg)
                ST_EXEC:
                    if (op_reg == OP_SELECT)
                    begin
                        active_reg         <= ch_reg;
                        blank_reg          <= blank_sum[TIME_BITS] ? TIME_MAX
                                              : blank_sum[TIME_BITS-1:0];
                        fall_ok_reg[ch_reg] <= 1'b0;
                        fall_reg[ch_reg]    <= '0;
                        low_ok_reg[ch_reg]  <= 1'b0;
                        low_reg[ch_reg]     <= '0;
                        skip_reg[ch_reg]    <= SKIP_AFTER_SELECT;
                    end
                ST_EDGE:
                    if (!e_blank_reg)
                    begin
                        if (skip_reg[ch_reg] != '0)
                        begin
                            if (!level_reg)
                                skip_reg[ch_reg] <= skip_reg[ch_reg] - 1'b1;
                            fall_ok_reg[ch_reg] <= 1'b0;
                            low_ok_reg[ch_reg]  <= 1'b0;
                        end
                        else if (!level_reg)
                        begin
                            low_reg[ch_reg]    <= now_reg;
                            low_ok_reg[ch_reg] <= 1'b1;
                        end
                        else if (low_ok_reg[ch_reg])
                        begin
                            low_ok_reg[ch_reg] <= 1'b0;
                            if (edge_ok)
                            begin
                                fall_reg[ch_reg]    <= low_reg[ch_reg];
                                fall_ok_reg[ch_reg] <= 1'b1;
                                if (fall_ok_reg[ch_reg] && period_ok)
                                begin
                                    good_reg[ch_reg]    <= now_reg;
                                    good_ok_reg[ch_reg] <= 1'b1;
                                    widx_reg[ch_reg]    <= widx_cur + 1'b1;
                                    if (count_reg[ch_reg] < COUNT_BITS'(RING_DEPTH))
                                        count_reg[ch_reg] <= count_reg[ch_reg] + 1'b1;
                                end
                            end
                        end
                    end
                ST_STOPCHK:
                    if (stop_now)
                    begin
                        count_reg[ch_reg]   <= '0;
                        widx_reg[ch_reg]    <= '0;
                        fall_ok_reg[ch_reg] <= 1'b0;
                        fall_reg[ch_reg]    <= '0;
                        low_ok_reg[ch_reg]  <= 1'b0;
                        low_reg[ch_reg]     <= '0;
                        filt_reg[ch_reg]    <= '0;
                        filt_ok_reg[ch_reg] <= 1'b0;
                        rep_reg[ch_reg]     <= '0;
                        rep_ok_reg[ch_reg]  <= 1'b1;
                    end
                ST_EMA:
                    if (!filt_ok_reg[ch_reg])
                    begin
                        filt_reg[ch_reg]    <= raw_reg;
                        filt_ok_reg[ch_reg] <= 1'b1;
                    end
                ST_EMA_DIV:
                    filt_reg[ch_reg] <= prod_reg[DIV5_SHIFT +: RPM_BITS];
                ST_REPORT:
                begin
                    rep_reg[ch_reg]    <= filt_reg[ch_reg];
                    rep_ok_reg[ch_reg] <= 1'b1;
                end
                ST_INVALID:
                    if (rep_ok_reg[ch_reg])
                    begin
                        rep_ok_reg[ch_reg]  <= 1'b0;
                        filt_ok_reg[ch_reg] <= 1'b0;
                        filt_reg[ch_reg]    <= '0;
                    end
                default:
                begin
                end
            endcase
        end
    end

    // ring storage, one write and one registered read
    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_EDGE) && !e_blank_reg && (skip_reg[ch_reg] == '0)
            && level_reg && low_ok_reg[ch_reg] && edge_ok
            && fall_ok_reg[ch_reg] && period_ok)
            ring_mem[wr_addr] <= per_sat;
        rd_data_reg <= ring_mem[rd_addr];
    end

    // item latch, flag capture and the median and rpm datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
                if (q_valid)
                begin
                    op_reg    <= q_item.op;
                    ch_reg    <= (q_item.op == OP_EDGE) ? active_reg : q_item.ch;
                    now_reg   <= q_item.now;
                    level_reg <= q_item.level;
                end
            ST_EXEC:
            begin
                e_blank_reg <= now_reg < blank_reg;
                e_early_reg <= now_reg < low_reg[ch_reg];
                e_width_reg <= now_reg - low_reg[ch_reg];
                e_back_reg  <= low_reg[ch_reg] < fall_reg[ch_reg];
                e_per_reg   <= low_reg[ch_reg] - fall_reg[ch_reg];
                s_ge_reg    <= now_reg >= good_reg[ch_reg];
                s_diff_reg  <= now_reg - good_reg[ch_reg];
            end
            ST_STOPCHK:
            begin
                n_reg       <= count_reg[ch_reg];
                sh_reg      <= SHIFT_BITS'((count_reg[ch_reg] - 1'b1) >> 1);
                ld_addr_reg <= '0;
                ins_cnt_reg <= '0;
                for (int i = 0; i < RING_DEPTH; i++)
                    row_reg[i] <= ROW_EMPTY;
                r_rpm_reg     <= '0;
                r_valid_reg   <= 1'b1;
                r_stopped_reg <= 1'b1;
                r_changed_reg <= !rep_ok_reg[ch_reg]
                                 || (rep_reg[ch_reg] >= RPM_BITS'(cfg.change_eps_q4))
                                    && (cfg.change_eps_q4 <= 16'(RPM_MAX));
            end
            ST_LOAD:
            begin
                if (ld_addr_reg < n_reg)
                    ld_addr_reg <= ld_addr_reg + 1'b1;
                if (rd_valid_reg)
                begin
                    row_reg     <= row_ins;
                    ins_cnt_reg <= ins_cnt_reg + 1'b1;
                end
            end
            ST_SHIFT:
                if (sh_reg != '0)
                begin
                    for (int i = 0; i < RING_DEPTH - 1; i++)
                        row_reg[i] <= row_reg[i+1];
                    row_reg[RING_DEPTH-1] <= ROW_EMPTY;
                    sh_reg <= sh_reg - 1'b1;
                end
                else
                    m2_reg <= m2_calc;
            ST_MUL:
                den_reg <= m2_reg * ppr_eff;
            ST_DIV:
                if (div_done)
                    raw_reg <= (quot > NUM_BITS'(RPM_MAX)) ? RPM_MAX : quot[RPM_BITS-1:0];
            ST_EMA:
                prod_reg <= ema_sum * DIV5_MUL;
            ST_REPORT:
            begin
                r_rpm_reg     <= filt_reg[ch_reg];
                r_valid_reg   <= 1'b1;
                r_stopped_reg <= 1'b0;
                r_changed_reg <= !rep_ok_reg[ch_reg]
                                 || (17'(rep_diff) >= RPM_BITS'(cfg.change_eps_q4))
                                    && (cfg.change_eps_q4 <= 16'(RPM_MAX));
            end
            ST_INVALID:
            begin
                r_rpm_reg     <= '0;
                r_valid_reg   <= 1'b0;
                r_stopped_reg <= 1'b0;
                r_changed_reg <= rep_ok_reg[ch_reg];
            end
            default:
            begin
            end
        endcase
    end

    // read data follows the address in the next cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rd_valid_reg <= 1'b0;
        else
            rd_valid_reg <= (state_reg == ST_LOAD) && (ld_addr_reg < n_reg);
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (out_load)
            res_valid_reg <= 1'b1;
        else if (!res_stall)
            res_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_ch_reg      <= ch_reg;
            out_rpm_reg     <= r_rpm_reg;
            out_valid_reg   <= r_valid_reg;
            out_changed_reg <= r_changed_reg;
            out_stopped_reg <= r_stopped_reg;
        end
    end

    assign res_valid   = res_valid_reg;
    assign out_channel = out_ch_reg;
    assign rpm_q4      = out_rpm_reg;
    assign rpm_valid   = out_valid_reg;
    assign changed     = out_changed_reg;
    assign stopped     = out_stopped_reg;

    `FT_ASSERT_IMP(a_stopped_zero, res_valid_reg && out_stopped_reg, (out_rpm_reg == '0) && out_valid_reg)
    `FT_ASSERT_IMP(a_invalid_zero, res_valid_reg && !out_valid_reg, (out_rpm_reg == '0) && !out_stopped_reg)
    `FT_ASSERT_IMP(a_div_in_place, div_done, state_reg == ST_DIV)
    `FT_ASSERT_IMP(a_insert_bound, rd_valid_reg, ins_cnt_reg < n_reg)

endmodule

[rtl/fan_tach_period_rpm_meter_unit.sv]
// Multiplexed fan tachometer for four channels sharing one tach line. After
// leaving the two-entry input queue, an edge request passes the execute and
// edge states and a select request the execute state alone; a measure request
// runs the stop check, reads the channel's period ring one entry a cycle into
// a sorting row, shifts to the median, scales by pulses per revolution and
// divides one quotient bit a cycle, then applies the rpm filter. A stop
// measure goes from the stop check straight to the output, and one without
// enough stored periods passes through the invalid state first.
// Results leave through an output register, so the next request is taken while
// a result waits. Ring entries are only read below the channel's fill count,
// so the ring needs no clearing after reset. Configuration writes are always
// accepted and are registered.
`include "assert_macros.svh"

module fan_tach_period_rpm_meter_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              req_valid,
    output logic                              req_stall,
    input  logic [1:0]                        req_type,
    input  logic [1:0]                        channel,
    input  logic [47:0]                       now_us,
    input  logic                              level,
    output logic                              res_valid,
    input  logic                              res_stall,
    output logic [1:0]                        out_channel,
    output logic [16:0]                       rpm_q4,
    output logic                              rpm_valid,
    output logic                              changed,
    output logic                              stopped,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [2:0]                        cfg_index,
    input  logic [23:0]                       cfg_data
);
    import fantach_pkg::*;

    cfg_t  cfg_reg;
    logic  q_valid;
    item_t q_item;
    logic  q_pop;
    logic  cfg_we;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_low_width_us <= 16'd50;
            cfg_reg.min_period_us    <= 18'd10000;
            cfg_reg.max_period_us    <= 18'd150000;
            cfg_reg.stop_timeout_us  <= 24'd4000000;
            cfg_reg.switch_blank_us  <= 16'd1000;
            cfg_reg.min_samples      <= 5'd2;
            cfg_reg.pulses_per_rev   <= 4'd2;
            cfg_reg.change_eps_q4    <= 16'd16;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_MIN_LOW:    cfg_reg.min_low_width_us <= cfg_data[15:0];
                CFG_MIN_PERIOD: cfg_reg.min_period_us    <= cfg_data[17:0];
                CFG_MAX_PERIOD: cfg_reg.max_period_us    <= cfg_data[17:0];
                CFG_STOP_TO:    cfg_reg.stop_timeout_us  <= cfg_data[23:0];
                CFG_BLANK:      cfg_reg.switch_blank_us  <= cfg_data[15:0];
                CFG_MIN_SAMP:   cfg_reg.min_samples      <= cfg_data[4:0];
                CFG_PPR:        cfg_reg.pulses_per_rev   <= cfg_data[3:0];
                CFG_EPS:        cfg_reg.change_eps_q4    <= cfg_data[15:0];
                default:
                begin
                end
            endcase
        end
    end

    fantach_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_type  (req_type),
        .channel   (channel),
        .now_us    (now_us),
        .level     (level),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop)
    );

    fantach_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .q_valid     (q_valid),
        .q_item      (q_item),
        .q_pop       (q_pop),
        .res_valid   (res_valid),
        .res_stall   (res_stall),
        .out_channel (out_channel),
        .rpm_q4      (rpm_q4),
        .rpm_valid   (rpm_valid),
        .changed     (changed),
        .stopped     (stopped)
    );

    `FT_ASSERT_IMP(a_pop_has_item, q_pop, q_valid)
    `FT_ASSERT_NEXT(a_cfg_lands, cfg_we && (cfg_index == CFG_MIN_SAMP), cfg_reg.min_samples == $past(cfg_data[4:0]))
    `FT_ASSERT_NEXT(a_ppr_lands, cfg_we && (cfg_index == CFG_PPR), cfg_reg.pulses_per_rev == $past(cfg_data[3:0]))

endmodule

[tb/fan_tach_period_rpm_meter_unit_chk.sv]
module fan_tach_period_rpm_meter_unit_chk
    import fantach_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    input  logic        req_stall,
    input  logic [1:0]  req_type,
    input  logic [1:0]  channel,
    input  logic [47:0] now_us,
    input  logic        level,
    input  logic        res_valid,
    input  logic        res_stall,
    input  logic [1:0]  out_channel,
    input  logic [16:0] rpm_q4,
    input  logic        rpm_valid,
    input  logic        changed,
    input  logic        stopped,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [23:0] cfg_data,
    output int          errors,
    output int          pending,
    output int          readings_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [1:0]  ch;
        logic [16:0] rpm;
        logic        valid;
        logic        chg;
        logic        stop;
    } reading_t;

    // per-channel tach state
    int unsigned     ring [CHANNELS][RING_DEPTH];
    int unsigned     fill [CHANNELS];
    int unsigned     widx [CHANNELS];
    longint unsigned fall_t [CHANNELS];
    longint unsigned low_t [CHANNELS];
    longint unsigned good_t [CHANNELS];
    bit              fall_ok [CHANNELS];
    bit              low_ok [CHANNELS];
    bit              good_ok [CHANNELS];
    int unsigned     skip [CHANNELS];
    int unsigned     filt [CHANNELS];
    bit              filt_ok [CHANNELS];
    int unsigned     rep [CHANNELS];
    bit              rep_ok [CHANNELS];
    int unsigned     act;
    longint unsigned blank_end;
    cfg_t            cfg;
    reading_t        readings [$];

    task automatic clear_state();
        for (int c = 0; c < CHANNELS; c++)
        begin
            for (int i = 0; i < RING_DEPTH; i++)
                ring[c][i] = 0;
            fill[c] = 0; widx[c] = 0;
            fall_t[c] = 0; low_t[c] = 0; good_t[c] = 0;
            fall_ok[c] = 0; low_ok[c] = 0; good_ok[c] = 0;
            skip[c] = 0; filt[c] = 0; filt_ok[c] = 0; rep[c] = 0; rep_ok[c] = 0;
        end
        act = 0;
        blank_end = 0;
        cfg.min_low_width_us = 50;
        cfg.min_period_us    = 10000;
        cfg.max_period_us    = 150000;
        cfg.stop_timeout_us  = 4000000;
        cfg.switch_blank_us  = 1000;
        cfg.min_samples      = 2;
        cfg.pulses_per_rev   = 2;
        cfg.change_eps_q4    = 16;
    endtask

    task automatic write_reg(logic [2:0] idx, logic [23:0] d);
        case (idx)
            CFG_MIN_LOW:    cfg.min_low_width_us = d[15:0];
            CFG_MIN_PERIOD: cfg.min_period_us    = d[17:0];
            CFG_MAX_PERIOD: cfg.max_period_us    = d[17:0];
            CFG_STOP_TO:    cfg.stop_timeout_us  = d[23:0];
            CFG_BLANK:      cfg.switch_blank_us  = d[15:0];
            CFG_MIN_SAMP:   cfg.min_samples      = d[4:0];
            CFG_PPR:        cfg.pulses_per_rev   = d[3:0];
            CFG_EPS:        cfg.change_eps_q4    = d[15:0];
            default: ;
        endcase
    endtask

    // edge on the shared tach line, credited to the selected channel
    task automatic tach_edge(longint unsigned now, logic lvl);
        longint unsigned start, prev, period;
        int unsigned c;
        if (now < blank_end)
            return;
        c = act;
        if (skip[c] > 0)
        begin
            if (!lvl)
                skip[c]--;
            fall_ok[c] = 0;
            low_ok[c] = 0;
            return;
        end
        if (!lvl)
        begin
            low_t[c] = now;
            low_ok[c] = 1;
            return;
        end
        if (!low_ok[c])
            return;
        low_ok[c] = 0;
        start = low_t[c];
        if (now < start || now - start < cfg.min_low_width_us)
            return;
        prev = fall_t[c];
        fall_t[c] = start;
        if (!fall_ok[c])
        begin
            fall_ok[c] = 1;
            return;
        end
        if (start < prev)
            return;
        period = start - prev;
        if (period < cfg.min_period_us || period > cfg.max_period_us)
            return;
        good_t[c] = now;
        good_ok[c] = 1;
        if (period > PERIOD_MAX)
            period = PERIOD_MAX;
        ring[c][widx[c]] = period;
        widx[c] = (widx[c] + 1) % RING_DEPTH;
        if (fill[c] < RING_DEPTH)
            fill[c]++;
    endtask

    task automatic select_channel(int unsigned c, longint unsigned now);
        longint unsigned e;
        act = c;
        e = now + cfg.switch_blank_us;
        blank_end = (e > TIME_MAX) ? TIME_MAX : e;
        fall_ok[c] = 0; fall_t[c] = 0;
        low_ok[c] = 0; low_t[c] = 0;
        skip[c] = SKIP_AFTER_SELECT;
    endtask

    // doubled median of the filled part of the ring
    function automatic longint unsigned median2(int unsigned c, int unsigned n);
        int unsigned v [RING_DEPTH];
        int unsigned t;
        for (int i = 0; i < n; i++)
            v[i] = ring[c][i];
        for (int i = 0; i < n; i++)
            for (int j = 0; j + 1 < n - i; j++)
                if (v[j] > v[j+1])
                begin
                    t = v[j]; v[j] = v[j+1]; v[j+1] = t;
                end
        if (n % 2)
            return 2 * longint'(v[n/2]);
        return longint'(v[n/2-1]) + longint'(v[n/2]);
    endfunction

    function automatic bit note_report(int unsigned c, int unsigned r);
        int unsigned d;
        bit chg;
        d = (r > rep[c]) ? r - rep[c] : rep[c] - r;
        chg = !rep_ok[c] || d >= cfg.change_eps_q4;
        rep[c] = r;
        rep_ok[c] = 1;
        return chg;
    endfunction

    function automatic reading_t measure_rpm(int unsigned c, longint unsigned now);
        reading_t r;
        longint unsigned m2, den, raw, ppr;
        int unsigned n;
        r.ch = c; r.rpm = 0; r.valid = 0; r.chg = 0; r.stop = 0;
        n = fill[c];
        // stop timeout wipes the channel
        if (good_ok[c] && now >= good_t[c] && now - good_t[c] > cfg.stop_timeout_us)
        begin
            for (int i = 0; i < RING_DEPTH; i++)
                ring[c][i] = 0;
            fill[c] = 0; widx[c] = 0;
            fall_ok[c] = 0; fall_t[c] = 0;
            low_ok[c] = 0; low_t[c] = 0;
            filt[c] = 0; filt_ok[c] = 0;
            r.valid = 1;
            r.chg = note_report(c, 0);
            r.stop = 1;
            return r;
        end
        m2 = 0;
        if (good_ok[c] && n > 0 && n >= cfg.min_samples)
            m2 = median2(c, n);
        if (m2 == 0)
        begin
            if (rep_ok[c])
            begin
                rep_ok[c] = 0; filt_ok[c] = 0; filt[c] = 0;
                r.chg = 1;
            end
            return r;
        end
        ppr = (cfg.pulses_per_rev == 0) ? 1 : cfg.pulses_per_rev;
        den = m2 * ppr;
        raw = (longint'(RPM_NUM) + den / 2) / den;
        if (raw > RPM_MAX)
            raw = RPM_MAX;
        if (!filt_ok[c])
        begin
            filt[c] = raw;
            filt_ok[c] = 1;
        end
        else
            filt[c] = (longint'(filt[c]) + 4 * raw + 2) / 5;
        r.rpm = filt[c];
        r.valid = 1;
        r.chg = note_report(c, filt[c]);
        return r;
    endfunction

    // watch the four channels
    always @(posedge clk or negedge rst_n)
    begin
        reading_t e;
        if (!rst_n)
        begin
            clear_state();
            readings.delete();
            errors = 0;
            readings_seen = 0;
        end
        else
        begin
            // check result first, it belongs to an earlier item
            if (res_valid && !res_stall)
            begin
                readings_seen++;
                if (readings.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected reading ch=%0d rpm=%0d", $time,
                             out_channel, rpm_q4);
                end
                else
                begin
                    e = readings.pop_front();
                    if (out_channel !== e.ch || rpm_q4 !== e.rpm || rpm_valid !== e.valid
                        || changed !== e.chg || stopped !== e.stop)
                    begin
                        errors++;
                        $display("%0t: expected ch=%0d rpm=%0d v=%0b chg=%0b stop=%0b",
                                 $time, e.ch, e.rpm, e.valid, e.chg, e.stop);
                        $display("%0t: actual   ch=%0d rpm=%0d v=%0b chg=%0b stop=%0b",
                                 $time, out_channel, rpm_q4, rpm_valid, changed, stopped);
                    end
                end
            end
            if (cfg_valid && cfg_ready)
                write_reg(cfg_index, cfg_data);
            if (req_valid && !req_stall)
            begin
                case (req_type)
                    REQ_EDGE:    tach_edge(now_us, level);
                    REQ_SELECT:  select_channel(channel, now_us);
                    REQ_MEASURE: readings.push_back(measure_rpm(channel, now_us));
                    default: ;
                endcase
            end
        end
        pending = readings.size();
    end

endmodule

[tb/fan_tach_period_rpm_meter_unit_tb.sv]
module fan_tach_period_rpm_meter_unit_tb;
    import fantach_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam int         ITEMS      = 2000;

    logic        clk;
    logic        rst_n;
    logic        req_valid;
    logic        req_stall;
    logic [1:0]  req_type;
    logic [1:0]  channel;
    logic [47:0] now_us;
    logic        level;
    logic        res_valid;
    logic        res_stall;
    logic [1:0]  out_channel;
    logic [16:0] rpm_q4;
    logic        rpm_valid;
    logic        changed;
    logic        stopped;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [23:0] cfg_data;
    int          errors;
    int          pending;
    int          readings_seen;

    // stimulus bookkeeping
    logic [47:0] t;
    int          sent;
    int          settings;
    bit          no_gaps;
    int unsigned min_low, min_per, max_per, stop_to, blank;

    fan_tach_period_rpm_meter_unit u_top (.*);

    fan_tach_period_rpm_meter_unit_chk u_chk (.*);

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #50ms;
        $display("Mismatches found");
        $finish;
    end

    // result side stalls
    initial
    begin
        int n;
        res_stall = 1;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            n = no_gaps ? 0 : $urandom_range(0, 16);
            res_stall = (n > 0);
            repeat (n) @(negedge clk);
            res_stall = 0;
            @(posedge clk);
            while (!res_valid) @(posedge clk);
        end
    end

    // one item on the request channel; called at a falling edge
    task automatic send(logic [1:0] rt, logic [1:0] ch, logic [47:0] now, logic lvl);
        int g;
        g = no_gaps ? 0 : $urandom_range(0, 16);
        if (g > 0)
        begin
            req_valid = 0;
            repeat (g) @(negedge clk);
        end
        req_valid = 1;
        req_type = rt;
        channel = ch;
        now_us = now;
        level = lvl;
        @(posedge clk);
        while (req_stall) @(posedge clk);
        @(negedge clk);
        sent++;
    endtask

    task automatic drain();
        req_valid = 0;
        while (pending != 0) @(negedge clk);
        repeat (100) @(negedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [23:0] d);
        cfg_valid = 1;
        cfg_index = idx;
        cfg_data = d;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_valid = 0;
    endtask

    task automatic apply_setting(int unsigned ml, int unsigned mnp, int unsigned mxp,
                                 int unsigned st, int unsigned bl, int unsigned ms,
                                 int unsigned pp, int unsigned ep);
        drain();
        write_reg(CFG_MIN_LOW, ml);
        write_reg(CFG_MIN_PERIOD, mnp);
        write_reg(CFG_MAX_PERIOD, mxp);
        write_reg(CFG_STOP_TO, st);
        write_reg(CFG_BLANK, bl);
        write_reg(CFG_MIN_SAMP, ms);
        write_reg(CFG_PPR, pp);
        write_reg(CFG_EPS, ep);
        min_low = ml; min_per = mnp; max_per = mxp; stop_to = st; blank = bl;
        settings++;
    endtask

    // one well-formed low pulse: falling then rising
    task automatic pulse(int unsigned p, int unsigned lw);
        send(REQ_EDGE, 0, t, 0);
        send(REQ_EDGE, 0, t + lw, 1);
        t += (p > lw) ? p : lw + 1;
    endtask

    // select a channel and run a pulse train with measures mixed in
    task automatic burst();
        int unsigned ch, lo, hi, base, p, lw, n;
        ch = $urandom_range(0, 3);
        send(REQ_SELECT, ch, t, $urandom_range(0, 1));
        t += blank + $urandom_range(0, 50);
        lo = (min_per < 1) ? 1 : min_per;
        hi = (max_per > 200000) ? 200000 : max_per;
        if (hi < lo)
            hi = lo;
        base = $urandom_range(lo, hi);
        n = $urandom_range(3, 20);
        for (int k = 0; k < n; k++)
        begin
            p = base + $urandom_range(0, base / 16);
            if ($urandom_range(0, 9) == 0)
                p = $urandom_range(1, hi * 2);
            lw = min_low + $urandom_range(0, 100);
            if ($urandom_range(0, 9) == 0)
                lw = $urandom_range(0, min_low);
            pulse(p, lw);
            if ($urandom_range(0, 3) == 0)
                send(REQ_MEASURE, ($urandom_range(0, 4) == 0) ? $urandom_range(0, 3) : ch,
                     t, $urandom_range(0, 1));
        end
    endtask

    initial
    begin
        int unsigned mn;
        rst_n = 0;
        req_valid = 0; req_type = REQ_EDGE; channel = 0; now_us = 0; level = 0;
        cfg_valid = 0; cfg_index = CFG_MIN_LOW; cfg_data = 0;
        sent = 0; settings = 1; no_gaps = 0;
        min_low = 50; min_per = 10000; max_per = 150000; stop_to = 4000000; blank = 1000;
        t = $urandom_range(1000, 1 << 30);
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // directed: reset settings
        send(REQ_MEASURE, 0, t, 0);
        send(REQ_EDGE, 0, t, 1);
        send(REQ_SELECT, 0, t, 0);
        t += 2000;
        for (int k = 0; k < 6; k++)
            pulse(20000, 100);
        send(REQ_MEASURE, 0, t, 0);
        pulse(20000, 10);
        send(REQ_MEASURE, 0, t, 1);
        send(REQ_UNUSED, 1, t, 1);
        send(REQ_MEASURE, 3, t, 0);
        t += 5000000;
        send(REQ_MEASURE, 0, t, 0);
        send(REQ_MEASURE, 0, t, 0);
        send(REQ_SELECT, 1, 48'hFFFF_FFFF_FFF0, 1);
        send(REQ_EDGE, 0, 48'hFFFF_FFFF_FFFF, 0);
        send(REQ_MEASURE, 1, 48'hFFFF_FFFF_FFFF, 1);

        // fixed settings, then random ones
        apply_setting(5, 100, 3000, 100000, 20, 1, 1, 0);
        no_gaps = 1;
        repeat (10) burst();
        no_gaps = 0;
        apply_setting(65535, 262143, 262143, 16777215, 65535, 31, 15, 65535);
        repeat (3) burst();
        apply_setting(0, 1, 262143, 1, 0, 16, 8, 65535);
        repeat (6) burst();
        apply_setting(0, 0, 50, 30, 0, 0, 0, 0);
        repeat (6) burst();

        while (sent < ITEMS)
        begin
            if (sent % 250 < 30)
            begin
                mn = $urandom_range(1, 5000);
                apply_setting($urandom_range(0, 200), mn, mn + $urandom_range(0, 50000),
                              $urandom_range(20000, 2000000), $urandom_range(0, 2000),
                              $urandom_range(0, 18), $urandom_range(0, 15),
                              $urandom_range(0, 200));
                no_gaps = ($urandom_range(0, 3) == 0);
            end
            case ($urandom_range(0, 19))
                0, 1, 2:
                    send($urandom_range(0, 3), $urandom_range(0, 3),
                         {$urandom, $urandom}, $urandom_range(0, 1));
                3, 4:
                begin
                    t += stop_to + $urandom_range(1, 1000);
                    send(REQ_MEASURE, $urandom_range(0, 3), t, 0);
                end
                5:
                    send(REQ_MEASURE, $urandom_range(0, 3), t, 1);
                default:
                    burst();
            endcase
        end

        drain();
        $display("sent %0d requests under %0d register settings, %0d readings checked",
                 sent, settings, readings_seen);
        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
